// ===== rtl/core/lne_pkg.sv =====
`default_nettype none
package lne_pkg;

  // Name store geometry
  localparam int NAME_MAX = 16;
  localparam int IDX_W    = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
  localparam int CNT_W    = $clog2(NAME_MAX + 1);

  // Command queue between front and back
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Field widths
  localparam int CHAR_W  = 7;
  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 3;
  localparam int LEN_W   = 5;
  localparam int SECS_W  = 8;
  localparam int CIDX_W  = 3;

  // Characters
  localparam logic [CHAR_W-1:0] CH_NUL = 7'h00;
  localparam logic [CHAR_W-1:0] CH_LF  = 7'h0A;
  localparam logic [CHAR_W-1:0] CH_CR  = 7'h0D;
  localparam logic [CHAR_W-1:0] CH_UA  = 7'h41;
  localparam logic [CHAR_W-1:0] CH_UZ  = 7'h5A;
  localparam logic [CHAR_W-1:0] CH_LA  = 7'h61;
  localparam logic [CHAR_W-1:0] CH_LZ  = 7'h7A;
  localparam logic [CHAR_W-1:0] CASE_OFS = 7'h20;

  // Result kinds
  localparam logic [KIND_W-1:0] K_ECHO    = 3'd0;
  localparam logic [KIND_W-1:0] K_CHAR    = 3'd1;
  localparam logic [KIND_W-1:0] K_DONE    = 3'd2;
  localparam logic [KIND_W-1:0] K_NULL    = 3'd3;
  localparam logic [KIND_W-1:0] K_EOT     = 3'd4;
  localparam logic [KIND_W-1:0] K_TIMEOUT = 3'd5;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_ERASE    = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_KILL     = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_EOT      = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_TMO_EN   = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_TMO_SECS = 3'd4;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_BYTE  = 2'd1,
    ACT_TICK  = 2'd2
  } action_t;

  typedef struct packed {
    logic [CHAR_W-1:0] erase_char;
    logic [CHAR_W-1:0] kill_char;
    logic [CHAR_W-1:0] eot_char;
    logic              tmo_en;
    logic [SECS_W-1:0] tmo_secs;
  } cfg_t;

  typedef struct packed {
    action_t           action;
    logic [BYTE_W-1:0] raw;
    logic [CHAR_W-1:0] ch;
    logic              is_null;
    logic              is_eot;
    logic              is_lower;
    logic              is_upper;
    logic              is_erase;
    logic              is_kill;
    logic              is_cr;
    logic              is_lf;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/lne_channels.sv =====
`default_nettype none
interface lne_in_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               action;
  logic [lne_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, action, rx_byte, input ready);
  modport sink   (input valid, action, rx_byte, output ready);
endinterface

interface lne_out_if;
  logic                       valid;
  logic                       ready;
  logic [lne_pkg::KIND_W-1:0] kind;
  logic [lne_pkg::BYTE_W-1:0] data_byte;
  logic [lne_pkg::LEN_W-1:0]  name_length;
  logic                       cr_mode;
  logic                       saw_upper;
  logic                       saw_lower;
  logic                       last;

  modport source (output valid, kind, data_byte, name_length, cr_mode, saw_upper,
                  saw_lower, last, input ready);
  modport sink   (input valid, kind, data_byte, name_length, cr_mode, saw_upper,
                  saw_lower, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lne_front.sv =====
`default_nettype none
module lne_front (
  lne_in_if.sink          in_ch,
  input  lne_pkg::cfg_t   cfg,
  input  logic            q_full,
  output logic            push,
  output lne_pkg::cmd_t   push_cmd
);

  logic [lne_pkg::CHAR_W-1:0] c;
  logic                       letter;
  logic                       known;

  assign in_ch.ready = !q_full;
  assign c = in_ch.rx_byte[lne_pkg::CHAR_W-1:0];

  // Drop unused action codes here; they never reach the back end
  assign known = (in_ch.action == lne_pkg::ACT_START) ||
                 (in_ch.action == lne_pkg::ACT_BYTE) ||
                 (in_ch.action == lne_pkg::ACT_TICK);
  assign push  = in_ch.valid && !q_full && known;

  always_comb begin
    push_cmd          = '0;
    push_cmd.action   = lne_pkg::action_t'(in_ch.action);
    push_cmd.raw      = in_ch.rx_byte;
    push_cmd.is_lower = (c >= lne_pkg::CH_LA) && (c <= lne_pkg::CH_LZ);
    push_cmd.is_upper = (c >= lne_pkg::CH_UA) && (c <= lne_pkg::CH_UZ);
    letter            = push_cmd.is_lower || push_cmd.is_upper;
    push_cmd.ch       = push_cmd.is_upper ? c + lne_pkg::CASE_OFS : c;
    push_cmd.is_null  = (c == lne_pkg::CH_NUL);
    push_cmd.is_eot   = !push_cmd.is_null && (c == cfg.eot_char);
    // Letters win over erase, erase wins over kill
    push_cmd.is_erase = !letter && (c == cfg.erase_char);
    push_cmd.is_kill  = !letter && !push_cmd.is_erase && (c == cfg.kill_char);
    push_cmd.is_cr    = (c == lne_pkg::CH_CR);
    push_cmd.is_lf    = (c == lne_pkg::CH_LF);
  end

endmodule
`default_nettype wire

// ===== rtl/core/lne_queue.sv =====
`default_nettype none
module lne_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lne_pkg::cmd_t     push_cmd,
  input  logic              pop,
  output lne_pkg::cmd_t     head,
  output lne_pkg::q_stat_t  stat
);

  lne_pkg::cmd_t                slots [lne_pkg::QDEPTH];
  logic [lne_pkg::QPTR_W-1:0]   wr_ptr;
  logic [lne_pkg::QPTR_W-1:0]   rd_ptr;
  logic [lne_pkg::QCNT_W-1:0]   fill;
  logic                         do_push;
  logic                         do_pop;

  function automatic logic [lne_pkg::QPTR_W-1:0] bump(input logic [lne_pkg::QPTR_W-1:0] p);
    return (p == lne_pkg::QPTR_W'(lne_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign stat.full  = (fill == lne_pkg::QCNT_W'(lne_pkg::QDEPTH));
  assign stat.empty = (fill == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/lne_back.sv =====
`default_nettype none
module lne_back (
  input  logic            clk,
  input  logic            rst,
  input  lne_pkg::cfg_t   cfg,
  input  lne_pkg::cmd_t   head,
  input  logic            head_valid,
  output logic            pop,
  lne_out_if.source       out_ch
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_ECHO   = 6'b000010,
    S_END    = 6'b000100,
    S_CHARS  = 6'b001000,
    S_DONE   = 6'b010000,
    S_SINGLE = 6'b100000
  } state_t;

  typedef struct packed {
    logic [lne_pkg::KIND_W-1:0] kind;
    logic [lne_pkg::BYTE_W-1:0] data_byte;
    logic [lne_pkg::LEN_W-1:0]  name_length;
    logic                       cr_mode;
    logic                       saw_upper;
    logic                       saw_lower;
    logic                       last;
  } res_t;

  logic [lne_pkg::CHAR_W-1:0] name_store [lne_pkg::NAME_MAX];
  logic [lne_pkg::CHAR_W-1:0] rd_data;

  state_t                     state, state_next;
  logic                       active, active_next;
  logic                       armed, armed_next;
  logic [lne_pkg::SECS_W-1:0] secs, secs_next, secs_inc;
  logic [lne_pkg::CNT_W-1:0]  count, count_next;
  logic                       up, up_next;
  logic                       lo, lo_next;
  logic                       by_cr, by_cr_next;
  logic                       do_cpl, do_cpl_next;
  logic [lne_pkg::BYTE_W-1:0] echo_byte, echo_byte_next;
  logic [lne_pkg::KIND_W-1:0] single_kind, single_kind_next;
  logic [lne_pkg::CNT_W-1:0]  idx, idx_next;
  logic                       out_valid, out_valid_next;
  res_t                       res, res_next;
  logic                       out_free;
  logic                       store_we;
  logic                       keep;

  assign out_free = !out_valid || out_ch.ready;
  assign pop      = (state == S_IDLE) && head_valid;

  assign out_ch.valid       = out_valid;
  assign out_ch.kind        = res.kind;
  assign out_ch.data_byte   = res.data_byte;
  assign out_ch.name_length = res.name_length;
  assign out_ch.cr_mode     = res.cr_mode;
  assign out_ch.saw_upper   = res.saw_upper;
  assign out_ch.saw_lower   = res.saw_lower;
  assign out_ch.last        = res.last;

  always_comb begin
    state_next       = state;
    active_next      = active;
    armed_next       = armed;
    secs_next        = secs;
    count_next       = count;
    up_next          = up;
    lo_next          = lo;
    by_cr_next       = by_cr;
    do_cpl_next      = do_cpl;
    echo_byte_next   = echo_byte;
    single_kind_next = single_kind;
    idx_next         = idx;
    out_valid_next   = out_valid && !out_ch.ready;
    res_next         = res;
    store_we         = 1'b0;
    keep             = 1'b0;
    secs_inc         = (secs == '1) ? secs : secs + 1'b1;

    unique case (state)
      S_IDLE: begin
        if (pop) begin
          case (head.action)
            lne_pkg::ACT_START: begin
              count_next  = '0;
              up_next     = 1'b0;
              lo_next     = 1'b0;
              active_next = 1'b1;
              armed_next  = cfg.tmo_en;
              secs_next   = '0;
            end
            lne_pkg::ACT_TICK: begin
              if (active && armed) begin
                secs_next = secs_inc;
                if (secs_inc >= cfg.tmo_secs) begin
                  single_kind_next = lne_pkg::K_TIMEOUT;
                  state_next       = S_SINGLE;
                  active_next      = 1'b0;
                  armed_next       = 1'b0;
                end
              end
            end
            lne_pkg::ACT_BYTE: begin
              if (active) begin
                if (head.is_null || head.is_eot) begin
                  single_kind_next = head.is_null ? lne_pkg::K_NULL : lne_pkg::K_EOT;
                  state_next       = S_SINGLE;
                  active_next      = 1'b0;
                  armed_next       = 1'b0;
                end else begin
                  echo_byte_next = head.raw;
                  state_next     = S_ECHO;
                  do_cpl_next    = 1'b0;
                  keep           = !head.is_erase && !head.is_kill;
                  if (head.is_lower) begin
                    lo_next = 1'b1;
                  end
                  if (head.is_upper) begin
                    up_next = 1'b1;
                  end
                  if (head.is_erase && (count != '0)) begin
                    count_next = count - 1'b1;
                  end
                  if (head.is_kill) begin
                    count_next = '0;
                  end
                  if (head.is_cr || head.is_lf) begin
                    do_cpl_next = 1'b1;
                    by_cr_next  = head.is_cr;
                  end else if (keep) begin
                    if (count >= lne_pkg::CNT_W'(lne_pkg::NAME_MAX)) begin
                      do_cpl_next = 1'b1;
                      by_cr_next  = 1'b0;
                    end else begin
                      store_we   = 1'b1;
                      count_next = count + 1'b1;
                    end
                  end
                  if (do_cpl_next) begin
                    active_next = 1'b0;
                    armed_next  = 1'b0;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_ECHO: begin
        if (out_free) begin
          out_valid_next     = 1'b1;
          res_next           = '0;
          res_next.kind      = lne_pkg::K_ECHO;
          res_next.data_byte = echo_byte;
          res_next.last      = !do_cpl;
          state_next         = do_cpl ? S_END : S_IDLE;
        end
      end
      S_END: begin
        if (out_free) begin
          out_valid_next     = 1'b1;
          res_next           = '0;
          res_next.kind      = lne_pkg::K_ECHO;
          res_next.data_byte = {1'b0, by_cr ? lne_pkg::CH_LF : lne_pkg::CH_CR};
          idx_next           = '0;
          state_next         = (count == '0) ? S_DONE : S_CHARS;
        end
      end
      S_CHARS: begin
        if (out_free) begin
          out_valid_next     = 1'b1;
          res_next           = '0;
          res_next.kind      = lne_pkg::K_CHAR;
          res_next.data_byte = {1'b0, rd_data};
          idx_next           = idx + 1'b1;
          if (idx_next == count) begin
            state_next = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_next       = 1'b1;
          res_next             = '0;
          res_next.kind        = lne_pkg::K_DONE;
          res_next.name_length = lne_pkg::LEN_W'(count);
          res_next.cr_mode     = by_cr;
          res_next.saw_upper   = up;
          res_next.saw_lower   = lo;
          res_next.last        = 1'b1;
          state_next           = S_IDLE;
        end
      end
      S_SINGLE: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          res_next       = '0;
          res_next.kind  = single_kind;
          res_next.last  = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Name store: one write port at the fill count, one registered read port
  always_ff @(posedge clk) begin
    if (store_we) begin
      name_store[count[lne_pkg::IDX_W-1:0]] <= head.ch;
    end
    rd_data <= name_store[idx_next[lne_pkg::IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      active    <= 1'b0;
      armed     <= 1'b0;
      secs      <= '0;
      count     <= '0;
      up        <= 1'b0;
      lo        <= 1'b0;
      do_cpl    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      active    <= active_next;
      armed     <= armed_next;
      secs      <= secs_next;
      count     <= count_next;
      up        <= up_next;
      lo        <= lo_next;
      do_cpl    <= do_cpl_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    by_cr       <= by_cr_next;
    echo_byte   <= echo_byte_next;
    single_kind <= single_kind_next;
    idx         <= idx_next;
    res         <= res_next;
  end

endmodule
`default_nettype wire

// ===== rtl/core/login_name_line_editor_core.sv =====
`default_nettype none
// A word accepted into the command queue is popped by the back end once it is idle.
// Results are registered and sent one at a time, holding while the output stalls; a
//   line completion gives echo, line end, name characters, done; else one result or none.
// A two-entry command queue lets the front accept while the back end streams a name.
// Reset (rst, synchronous): session idle, queue and output empty, config to defaults;
//   the name store is not cleared and is only read below the fill count.
module login_name_line_editor_core (
  input  logic                        clk,
  input  logic                        rst,
  lne_in_if.sink                      in_ch,
  lne_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [lne_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [lne_pkg::SECS_W-1:0]  cfg_data
);

  lne_pkg::cfg_t     cfg;
  lne_pkg::cmd_t     push_cmd;
  lne_pkg::cmd_t     head;
  lne_pkg::q_stat_t  q_stat;
  logic              push;
  logic              pop;

  // Configuration registers; the user must write them only while the block is idle (not enforced)
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.erase_char <= 7'd35;
      cfg.kill_char  <= 7'd64;
      cfg.eot_char   <= 7'd4;
      cfg.tmo_en     <= 1'b0;
      cfg.tmo_secs   <= 8'd60;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lne_pkg::CFG_ERASE:    cfg.erase_char <= cfg_data[lne_pkg::CHAR_W-1:0];
        lne_pkg::CFG_KILL:     cfg.kill_char  <= cfg_data[lne_pkg::CHAR_W-1:0];
        lne_pkg::CFG_EOT:      cfg.eot_char   <= cfg_data[lne_pkg::CHAR_W-1:0];
        lne_pkg::CFG_TMO_EN:   cfg.tmo_en     <= cfg_data[0];
        lne_pkg::CFG_TMO_SECS: cfg.tmo_secs   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: accept words, fold case and flag special characters
  lne_front u_front (
    .in_ch    (in_ch),
    .cfg      (cfg),
    .q_full   (q_stat.full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Hold classified commands until the back end is free
  lne_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  // Back: keep the session state, edit the name store, stream results
  lne_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .head_valid (!q_stat.empty),
    .pop        (pop),
    .out_ch     (out_ch)
  );

  // Queue cannot be full and empty at once
  a_q_stat: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue status inconsistent");

  // Session-ending results are always the final word of their input
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && (out_ch.kind == lne_pkg::K_NULL || out_ch.kind == lne_pkg::K_EOT ||
     out_ch.kind == lne_pkg::K_TIMEOUT || out_ch.kind == lne_pkg::K_DONE)) |-> out_ch.last)
    else $error("terminal result without last");

  // Streamed name characters are 7-bit and already folded to lowercase
  a_char_folded: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.kind == lne_pkg::K_CHAR) |->
    (!out_ch.data_byte[7] && !out_ch.last &&
     !(out_ch.data_byte[6:0] >= lne_pkg::CH_UA && out_ch.data_byte[6:0] <= lne_pkg::CH_UZ)))
    else $error("name character not folded");

  // No word is taken while the queue is full
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_stat.full |-> !push)
    else $error("push into full queue");

endmodule
`default_nettype wire
